/* src/first_fit_chunk_allocator_unit_defines.svh */
// assertion macros shared by the allocator rtl
`ifndef FIRST_FIT_CHUNK_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_CHUNK_ALLOCATOR_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define FFCA_ASSERT_IMP(name, clk, rstn, a, c) \
	name: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
		else $error("ffca assertion failed");
// next-cycle implication
`define FFCA_ASSERT_NEXT(name, clk, rstn, a, c) \
	name: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
		else $error("ffca assertion failed");
`else
`define FFCA_ASSERT_IMP(name, clk, rstn, a, c)
`define FFCA_ASSERT_NEXT(name, clk, rstn, a, c)
`endif
`endif

/* src/ffca_pkg.sv */
// types and constants of the first-fit chunk allocator
`timescale 1ns / 1ps
package ffca_pkg;
	localparam int DEF_TABLE_DEPTH = 64;
	localparam int DEF_ADDR_WIDTH  = 32;
	localparam logic [31:0] HEAP_LIMIT_RST = 32'd65536;

	// configuration register indexes
	localparam logic REG_HEAP_BASE  = 1'b0;
	localparam logic REG_HEAP_LIMIT = 1'b1;

	// table select
	localparam logic TBL_USED  = 1'b0;
	localparam logic TBL_SPARE = 1'b1;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_ZERO_SIZE  = 3'd1,
		ST_NO_SPACE   = 3'd2,
		ST_TABLE_FULL = 3'd3,
		ST_NOT_FOUND  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		JOB_FIT,
		JOB_BUMP,
		JOB_FREE
	} job_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_COAL_RD,
		S_COAL_CHK,
		S_FIT_RD,
		S_FIT_CHK,
		S_SRCH_RD,
		S_SRCH_CHK,
		S_DISP,
		S_INS_RD,
		S_INS_CHK,
		S_REM_RD,
		S_REM_WR,
		S_FIN
	} state_t;
endpackage

/* src/ffca_ram.sv */
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module ffca_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* src/first_fit_chunk_allocator_unit.sv */
// top level of the first-fit chunk allocator
`timescale 1ns / 1ps
`include "first_fit_chunk_allocator_unit_defines.svh"
// First-fit chunk allocator. Each request allocates (tuser 0) or frees (tuser 1) one
// chunk and returns exactly one result with a status and the running byte counters.
// The allocated and free tables each live in a one-port-write, one-port-read RAM of
// TABLE_DEPTH entries, and every table walk handles one entry at a time (read issue,
// then compare or move). An allocation coalesces the free table, scans it for the
// first fit (or grows the bump region), inserts the chunk sorted into the allocated
// table, then removes the used free entry and inserts any tail; a free searches the
// allocated table, inserts the chunk into the free table and removes it from the
// allocated table. A zero-size allocation skips the table walks. The result sits
// in an output register, so a new request is taken while the last result waits.
module first_fit_chunk_allocator_unit import ffca_pkg::*; #(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
	parameter int ADDR_WIDTH  = DEF_ADDR_WIDTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [31:0]  cfg_wdata,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [63:0]  s_axis_tdata,   // request_size, release_address
	input  logic         s_axis_tuser,   // mode
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [159:0] m_axis_tdata,   // granted_address, bytes_in_use, region_used,
	                                     // bytes_ever_granted
	output logic [2:0]   m_axis_tuser    // status
);
	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int AW = ADDR_WIDTH;
	localparam int EW = AW + 32;
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	// address helpers, wrapping modulo 2^ADDR_WIDTH
	function automatic logic [AW-1:0] addr_of32(input logic [31:0] v);
		logic [63:0] w;
		w = 64'(v);
		return w[AW-1:0];
	endfunction

	function automatic logic [31:0] addr_to32(input logic [AW-1:0] a);
		logic [63:0] w;
		w = 64'(a);
		return w[31:0];
	endfunction

	function automatic logic [AW-1:0] addr_add(input logic [AW-1:0] a, input logic [31:0] b);
		logic [AW:0] s;
		s = {1'b0, a} + (AW+1)'(b);
		return s[AW-1:0];
	endfunction

	state_t          state_q, state_d;
	job_t            job_q, job_d;
	status_t         stat_q, stat_d;
	logic [1:0]      step_q, step_d;
	logic            tbl_q, tbl_d;
	logic [31:0]     base_q, limit_q;
	logic [CW-1:0]   used_cnt_q, used_cnt_d, spare_cnt_q, spare_cnt_d;
	logic [31:0]     grown_q, grown_d, live_q, live_d;
	logic [63:0]     total_q, total_d;
	logic [CW-1:0]   idx_q, idx_d, n_q, n_d, fnd_q, fnd_d;
	logic            ov_q, ov_d;

	logic [31:0]     size_q, size_d;
	logic [AW-1:0]   rel_q, rel_d;
	logic [AW-1:0]   ent_s_q, ent_s_d, g_s_q, g_s_d;
	logic [31:0]     ent_l_q, ent_l_d, g_l_q, g_l_d, tail_q, tail_d;
	logic [31:0]     addr_q, addr_d;
	logic [31:0]     o_addr_q, o_live_q, o_grown_q;
	logic [63:0]     o_total_q;
	status_t         o_stat_q;
	logic            o_load;

	// ram ports
	logic            u_we, s_we;
	logic [IW-1:0]   u_waddr, s_waddr, u_raddr, s_raddr;
	logic [EW-1:0]   u_wdata, s_wdata, u_rdata, s_rdata;

	// shared access path, routed to one table
	logic            sel_spare;
	logic            wr_en;
	logic [CW-1:0]   wr_idx, rd_idx;
	logic [EW-1:0]   wr_data, rd_data;
	logic [AW-1:0]   rd_s;
	logic [31:0]     rd_l;
	logic [CW-1:0]   sel_cnt;

	logic [AW-1:0]   coal_end;
	logic [32:0]     coal_sum;
	logic [32:0]     bump_sum;
	logic [64:0]     total_sum;
	logic [32:0]     live_sum;

	ffca_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_used_ram (
		.clk(clk), .we(u_we), .waddr(u_waddr), .wdata(u_wdata),
		.raddr(u_raddr), .rdata(u_rdata)
	);

	ffca_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_spare_ram (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
		.raddr(s_raddr), .rdata(s_rdata)
	);

	// table select per state
	always_comb begin
		unique case (state_q)
			S_COAL_RD, S_COAL_CHK, S_FIT_RD, S_FIT_CHK: sel_spare = TBL_SPARE;
			S_SRCH_RD, S_SRCH_CHK:                      sel_spare = TBL_USED;
			default:                                    sel_spare = tbl_q;
		endcase
	end

	assign rd_data = (sel_spare == TBL_SPARE) ? s_rdata : u_rdata;
	assign rd_s    = rd_data[EW-1:32];
	assign rd_l    = rd_data[31:0];
	assign sel_cnt = (sel_spare == TBL_SPARE) ? spare_cnt_q : used_cnt_q;

	assign u_we    = wr_en && (sel_spare == TBL_USED);
	assign s_we    = wr_en && (sel_spare == TBL_SPARE);
	assign u_waddr = wr_idx[IW-1:0];
	assign s_waddr = wr_idx[IW-1:0];
	assign u_wdata = wr_data;
	assign s_wdata = wr_data;
	assign u_raddr = rd_idx[IW-1:0];
	assign s_raddr = rd_idx[IW-1:0];

	// arithmetic shared by the sequencer
	assign coal_end  = addr_add(ent_s_q, ent_l_q);
	assign coal_sum  = {1'b0, ent_l_q} + {1'b0, rd_l};
	assign bump_sum  = {1'b0, grown_q} + {1'b0, size_q};
	assign total_sum = {1'b0, total_q} + 65'(size_q);
	assign live_sum  = {1'b0, live_q} + {1'b0, size_q};

	// sequencer: next state and datapath
	always_comb begin
		state_d     = state_q;
		job_d       = job_q;
		stat_d      = stat_q;
		step_d      = step_q;
		tbl_d       = tbl_q;
		used_cnt_d  = used_cnt_q;
		spare_cnt_d = spare_cnt_q;
		grown_d     = grown_q;
		live_d      = live_q;
		total_d     = total_q;
		idx_d       = idx_q;
		n_d         = n_q;
		fnd_d       = fnd_q;
		size_d      = size_q;
		rel_d       = rel_q;
		ent_s_d     = ent_s_q;
		ent_l_d     = ent_l_q;
		g_s_d       = g_s_q;
		g_l_d       = g_l_q;
		tail_d      = tail_q;
		addr_d      = addr_q;
		ov_d        = ov_q && !m_axis_tready;
		o_load      = 1'b0;
		wr_en       = 1'b0;
		wr_idx      = '0;
		wr_data     = {ent_s_q, ent_l_q};
		rd_idx      = idx_q;
		s_axis_tready = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					size_d = s_axis_tdata[31:0];
					rel_d  = addr_of32(s_axis_tdata[63:32]);
					stat_d = ST_OK;
					addr_d = '0;
					idx_d  = '0;
					n_d    = '0;
					if (s_axis_tuser) begin
						state_d = S_SRCH_RD;
					end else if (s_axis_tdata[31:0] == 32'd0) begin
						stat_d  = ST_ZERO_SIZE;
						state_d = S_FIN;
					end else begin
						state_d = S_COAL_RD;
					end
				end
			end

			// coalesce the free table in place
			S_COAL_RD: begin
				if (idx_q >= spare_cnt_q) begin
					if (n_q != '0) begin
						wr_en  = 1'b1;
						wr_idx = n_q - 1'b1;
					end
					spare_cnt_d = n_q;
					idx_d       = '0;
					if (used_cnt_q >= DEPTH_C) begin
						stat_d  = ST_TABLE_FULL;
						state_d = S_FIN;
					end else begin
						state_d = S_FIT_RD;
					end
				end else begin
					state_d = S_COAL_CHK;
				end
			end
			S_COAL_CHK: begin
				if (n_q != '0 && coal_end == rd_s && !coal_sum[32]) begin
					ent_l_d = coal_sum[31:0];
				end else begin
					if (n_q != '0) begin
						wr_en  = 1'b1;
						wr_idx = n_q - 1'b1;
					end
					ent_s_d = rd_s;
					ent_l_d = rd_l;
					n_d     = n_q + 1'b1;
				end
				idx_d   = idx_q + 1'b1;
				state_d = S_COAL_RD;
			end

			// first-fit scan, then bump growth
			S_FIT_RD: begin
				if (idx_q >= spare_cnt_q) begin
					if (bump_sum > {1'b0, limit_q}) begin
						stat_d  = ST_NO_SPACE;
						state_d = S_FIN;
					end else begin
						g_s_d   = addr_add(addr_of32(base_q), grown_q);
						g_l_d   = size_q;
						addr_d  = addr_to32(addr_add(addr_of32(base_q), grown_q));
						grown_d = bump_sum[31:0];
						live_d  = live_sum[32] ? 32'hFFFF_FFFF : live_sum[31:0];
						total_d = total_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : total_sum[63:0];
						job_d   = JOB_BUMP;
						step_d  = '0;
						state_d = S_DISP;
					end
				end else begin
					state_d = S_FIT_CHK;
				end
			end
			S_FIT_CHK: begin
				if (rd_l >= size_q) begin
					g_s_d   = rd_s;
					g_l_d   = size_q;
					addr_d  = addr_to32(rd_s);
					tail_d  = rd_l - size_q;
					fnd_d   = idx_q;
					live_d  = live_sum[32] ? 32'hFFFF_FFFF : live_sum[31:0];
					total_d = total_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : total_sum[63:0];
					job_d   = JOB_FIT;
					step_d  = '0;
					state_d = S_DISP;
				end else begin
					idx_d   = idx_q + 1'b1;
					state_d = S_FIT_RD;
				end
			end

			// exact-address lookup for a free
			S_SRCH_RD: begin
				if (idx_q >= used_cnt_q) begin
					stat_d  = ST_NOT_FOUND;
					state_d = S_FIN;
				end else begin
					state_d = S_SRCH_CHK;
				end
			end
			S_SRCH_CHK: begin
				if (rd_s == rel_q) begin
					if (spare_cnt_q >= DEPTH_C) begin
						stat_d  = ST_TABLE_FULL;
						state_d = S_FIN;
					end else begin
						g_s_d   = rd_s;
						g_l_d   = rd_l;
						fnd_d   = idx_q;
						live_d  = (live_q >= rd_l) ? live_q - rd_l : 32'd0;
						job_d   = JOB_FREE;
						step_d  = '0;
						state_d = S_DISP;
					end
				end else begin
					idx_d   = idx_q + 1'b1;
					state_d = S_SRCH_RD;
				end
			end

			// launch the table edits of the job one after another
			S_DISP: begin
				step_d  = step_q + 1'b1;
				state_d = S_FIN;
				unique case (job_q)
					JOB_FIT: begin
						if (step_q == 2'd0) begin
							tbl_d   = TBL_USED;
							ent_s_d = g_s_q;
							ent_l_d = g_l_q;
							idx_d   = used_cnt_q;
							state_d = S_INS_RD;
						end else if (step_q == 2'd1) begin
							tbl_d   = TBL_SPARE;
							idx_d   = fnd_q;
							state_d = S_REM_RD;
						end else if (step_q == 2'd2 && tail_q != 32'd0) begin
							tbl_d   = TBL_SPARE;
							ent_s_d = addr_add(g_s_q, g_l_q);
							ent_l_d = tail_q;
							idx_d   = spare_cnt_q;
							state_d = S_INS_RD;
						end
					end
					JOB_BUMP: begin
						if (step_q == 2'd0) begin
							tbl_d   = TBL_USED;
							ent_s_d = g_s_q;
							ent_l_d = g_l_q;
							idx_d   = used_cnt_q;
							state_d = S_INS_RD;
						end
					end
					JOB_FREE: begin
						if (step_q == 2'd0) begin
							tbl_d   = TBL_SPARE;
							ent_s_d = g_s_q;
							ent_l_d = g_l_q;
							idx_d   = spare_cnt_q;
							state_d = S_INS_RD;
						end else if (step_q == 2'd1) begin
							tbl_d   = TBL_USED;
							idx_d   = fnd_q;
							state_d = S_REM_RD;
						end
					end
					default: state_d = S_FIN;
				endcase
			end

			// sorted insert, shifting larger starts up by one
			S_INS_RD: begin
				rd_idx = idx_q - 1'b1;
				if (idx_q == '0) begin
					wr_en  = 1'b1;
					wr_idx = '0;
					if (tbl_q == TBL_SPARE) begin
						spare_cnt_d = spare_cnt_q + 1'b1;
					end else begin
						used_cnt_d = used_cnt_q + 1'b1;
					end
					state_d = S_DISP;
				end else begin
					state_d = S_INS_CHK;
				end
			end
			S_INS_CHK: begin
				wr_en  = 1'b1;
				wr_idx = idx_q;
				if (rd_s > ent_s_q) begin
					wr_data = rd_data;
					idx_d   = idx_q - 1'b1;
					state_d = S_INS_RD;
				end else begin
					if (tbl_q == TBL_SPARE) begin
						spare_cnt_d = spare_cnt_q + 1'b1;
					end else begin
						used_cnt_d = used_cnt_q + 1'b1;
					end
					state_d = S_DISP;
				end
			end

			// remove one entry, shifting the rest down
			S_REM_RD: begin
				rd_idx = idx_q + 1'b1;
				if (idx_q + 1'b1 >= sel_cnt) begin
					if (tbl_q == TBL_SPARE) begin
						spare_cnt_d = spare_cnt_q - 1'b1;
					end else begin
						used_cnt_d = used_cnt_q - 1'b1;
					end
					state_d = S_DISP;
				end else begin
					state_d = S_REM_WR;
				end
			end
			S_REM_WR: begin
				wr_en   = 1'b1;
				wr_idx  = idx_q;
				wr_data = rd_data;
				idx_d   = idx_q + 1'b1;
				state_d = S_REM_RD;
			end

			// hand the result to the output register
			S_FIN: begin
				if (!ov_q || m_axis_tready) begin
					o_load  = 1'b1;
					ov_d    = 1'b1;
					state_d = S_IDLE;
				end
			end

			default: state_d = S_IDLE;
		endcase
	end

	// control state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			job_q       <= JOB_FIT;
			step_q      <= '0;
			tbl_q       <= TBL_USED;
			base_q      <= '0;
			limit_q     <= HEAP_LIMIT_RST;
			used_cnt_q  <= '0;
			spare_cnt_q <= '0;
			grown_q     <= '0;
			live_q      <= '0;
			total_q     <= '0;
			idx_q       <= '0;
			n_q         <= '0;
			fnd_q       <= '0;
			ov_q        <= 1'b0;
		end else begin
			state_q     <= state_d;
			job_q       <= job_d;
			step_q      <= step_d;
			tbl_q       <= tbl_d;
			used_cnt_q  <= used_cnt_d;
			spare_cnt_q <= spare_cnt_d;
			grown_q     <= grown_d;
			live_q      <= live_d;
			total_q     <= total_d;
			idx_q       <= idx_d;
			n_q         <= n_d;
			fnd_q       <= fnd_d;
			ov_q        <= ov_d;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_HEAP_BASE:  base_q  <= cfg_wdata;
					REG_HEAP_LIMIT: limit_q <= cfg_wdata;
					default: ;
				endcase
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		stat_q  <= stat_d;
		size_q  <= size_d;
		rel_q   <= rel_d;
		ent_s_q <= ent_s_d;
		ent_l_q <= ent_l_d;
		g_s_q   <= g_s_d;
		g_l_q   <= g_l_d;
		tail_q  <= tail_d;
		addr_q  <= addr_d;
		if (o_load) begin
			o_addr_q  <= addr_q;
			o_stat_q  <= stat_q;
			o_live_q  <= live_q;
			o_grown_q <= grown_q;
			o_total_q <= total_q;
		end
	end

	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata  = {o_total_q, o_grown_q, o_live_q, o_addr_q};
	assign m_axis_tuser  = o_stat_q;

	// table counts stay within the table depth
	`FFCA_ASSERT_IMP(a_used_cnt_range, clk, arst_n, 1'b1, used_cnt_q <= DEPTH_C)
	`FFCA_ASSERT_IMP(a_spare_cnt_range, clk, arst_n, 1'b1, spare_cnt_q <= DEPTH_C)
	// an accepted request starts work
	`FFCA_ASSERT_NEXT(a_accept_busy, clk, arst_n, s_axis_tvalid && s_axis_tready, state_q != S_IDLE)
	// total granted bytes never shrink
	`FFCA_ASSERT_NEXT(a_total_mono, clk, arst_n, 1'b1, total_q >= $past(total_q))
endmodule

/* tb/first_fit_chunk_allocator_unit_tb.sv */
// self-checking testbench of the first-fit chunk allocator
`timescale 1ns / 1ps
module first_fit_chunk_allocator_unit_tb;
	import ffca_pkg::*;

	localparam int DEPTH       = 64;
	localparam int CYCLE_LIMIT = 3000000;

	typedef struct {
		logic [31:0] addr;
		status_t     st;
		logic [31:0] live;
		logic [31:0] grown;
		logic [63:0] total;
	} alloc_result_t;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic         cfg_index;
	logic [31:0]  cfg_wdata;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [63:0]  s_axis_tdata;   // request_size, release_address
	logic         s_axis_tuser;   // mode
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [159:0] m_axis_tdata;   // granted_address, bytes_in_use, region_used,
	                              // bytes_ever_granted
	logic [2:0]   m_axis_tuser;   // status

	// shadow copy of the allocator state
	logic [31:0] used_st[$];
	logic [31:0] used_ln[$];
	logic [31:0] free_st[$];
	logic [31:0] free_ln[$];
	logic [31:0] m_base;
	logic [31:0] m_limit;
	logic [31:0] m_grown;
	logic [31:0] m_live;
	logic [63:0] m_total;

	alloc_result_t pending_results[$];
	int errors;
	int cycles;
	int tx_idle;
	int rx_idle;

	first_fit_chunk_allocator_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run-length guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("first_fit_chunk_allocator_unit_tb: FAIL");
			$finish;
		end
	end

	// result backpressure
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= rx_idle);
	end

	// sorted inserts, new entry after equal starts
	function automatic void add_used(logic [31:0] s, logic [31:0] l);
		int i;
		i = used_st.size();
		while (i > 0 && used_st[i-1] > s) i--;
		used_st.insert(i, s);
		used_ln.insert(i, l);
	endfunction

	function automatic void add_free(logic [31:0] s, logic [31:0] l);
		int i;
		i = free_st.size();
		while (i > 0 && free_st[i-1] > s) i--;
		free_st.insert(i, s);
		free_ln.insert(i, l);
	endfunction

	// join touching free neighbours unless the length overflows
	function automatic void merge_free();
		logic [31:0] ns[$];
		logic [31:0] nl[$];
		logic [32:0] sum;
		logic [31:0] e;
		int k;
		for (int i = 0; i < free_st.size(); i++) begin
			if (ns.size() > 0) begin
				k = ns.size() - 1;
				e = ns[k] + nl[k];
				sum = {1'b0, nl[k]} + {1'b0, free_ln[i]};
				if (e == free_st[i] && !sum[32]) begin
					nl[k] = sum[31:0];
					continue;
				end
			end
			ns.push_back(free_st[i]);
			nl.push_back(free_ln[i]);
		end
		free_st = ns;
		free_ln = nl;
	endfunction

	function automatic void count_grant(logic [31:0] size);
		logic [32:0] lv;
		lv = {1'b0, m_live} + {1'b0, size};
		m_live = lv[32] ? 32'hFFFF_FFFF : lv[31:0];
		m_total = (m_total > (64'hFFFF_FFFF_FFFF_FFFF - size)) ? 64'hFFFF_FFFF_FFFF_FFFF
		                                                     : m_total + size;
	endfunction

	// expected outcome of one request, updates the shadow state
	function automatic alloc_result_t predict_request(logic mode, logic [31:0] size,
	                                                  logic [31:0] rel);
		alloc_result_t r;
		int idx;
		logic [31:0] s;
		logic [31:0] tail;
		logic [31:0] l;
		bit found;
		r.addr = '0;
		r.st = ST_OK;
		if (!mode) begin
			if (size == 0) begin
				r.st = ST_ZERO_SIZE;
			end else begin
				merge_free();
				if (used_st.size() >= DEPTH) begin
					r.st = ST_TABLE_FULL;
				end else begin
					found = 1'b0;
					for (int i = 0; i < free_st.size() && !found; i++) begin
						if (free_ln[i] >= size) begin
							s = free_st[i];
							tail = free_ln[i] - size;
							free_st.delete(i);
							free_ln.delete(i);
							add_used(s, size);
							count_grant(size);
							if (tail > 0) add_free(s + size, tail);
							r.addr = s;
							found = 1'b1;
						end
					end
					if (!found) begin
						if ({1'b0, m_grown} + {1'b0, size} > {1'b0, m_limit}) begin
							r.st = ST_NO_SPACE;
						end else begin
							s = m_base + m_grown;
							add_used(s, size);
							m_grown = m_grown + size;
							count_grant(size);
							r.addr = s;
						end
					end
				end
			end
		end else begin
			idx = -1;
			for (int i = 0; i < used_st.size(); i++)
				if (idx < 0 && used_st[i] == rel) idx = i;
			if (idx < 0) begin
				r.st = ST_NOT_FOUND;
			end else if (free_st.size() >= DEPTH) begin
				r.st = ST_TABLE_FULL;
			end else begin
				l = used_ln[idx];
				m_live = (m_live >= l) ? m_live - l : 32'd0;
				add_free(used_st[idx], l);
				used_st.delete(idx);
				used_ln.delete(idx);
			end
		end
		r.live = m_live;
		r.grown = m_grown;
		r.total = m_total;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0h expected %0h", what, got, want);
		errors++;
	endtask

	// compare every result with the oldest expectation
	always @(posedge clk) begin
		alloc_result_t w;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", m_axis_tdata[63:0], 64'd0);
			end else begin
				w = pending_results.pop_front();
				if (m_axis_tdata[31:0] !== w.addr)
					report_mismatch("granted_address", m_axis_tdata[31:0], w.addr);
				if (m_axis_tuser !== w.st)
					report_mismatch("status", m_axis_tuser, w.st);
				if (m_axis_tdata[63:32] !== w.live)
					report_mismatch("bytes_in_use", m_axis_tdata[63:32], w.live);
				if (m_axis_tdata[95:64] !== w.grown)
					report_mismatch("region_used", m_axis_tdata[95:64], w.grown);
				if (m_axis_tdata[159:96] !== w.total)
					report_mismatch("bytes_ever_granted", m_axis_tdata[159:96], w.total);
			end
		end
	end

	// one request through the slave port
	task automatic send_request(logic mode, logic [31:0] size, logic [31:0] rel);
		while ($urandom_range(0, 99) < tx_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= mode;
		s_axis_tdata  <= {rel, size};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pending_results.push_back(predict_request(mode, size, rel));
	endtask

	// stop sending until every result is back
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() > 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// both registers, only while idle
	task automatic set_heap(logic [31:0] base, logic [31:0] limit);
		cfg_we    <= 1'b1;
		cfg_index <= REG_HEAP_BASE;
		cfg_wdata <= base;
		@(posedge clk);
		cfg_index <= REG_HEAP_LIMIT;
		cfg_wdata <= limit;
		@(posedge clk);
		cfg_we <= 1'b0;
		m_base  = base;
		m_limit = limit;
		@(posedge clk);
	endtask

	task automatic test_basic();
		set_heap(32'd0, 32'd65536);
		send_request(1'b0, 32'd0, 32'hFFFF_FFFF);   // zero size
		send_request(1'b1, 32'hFFFF_FFFF, 32'd0);   // free of unknown address 0
		send_request(1'b0, 32'd16, 32'd0);
		send_request(1'b1, 32'd0, 32'd0);           // free of address 0
		send_request(1'b0, 32'd8, 32'd0);           // fits the freed chunk
		send_request(1'b0, 32'd8, 32'd0);
		send_request(1'b0, 32'd8, 32'd0);
		send_request(1'b0, 32'd8, 32'd0);
		send_request(1'b1, 32'd0, 32'd8);
		send_request(1'b1, 32'd0, 32'd16);
		send_request(1'b0, 32'd4, 32'd0);           // coalesce then split
		send_request(1'b0, 32'd12, 32'd0);
		send_request(1'b0, 32'hFFFF_FFFF, 32'd0);   // no space
		send_request(1'b0, 32'd65536, 32'd0);
		send_request(1'b1, 32'd0, 32'hFFFF_FFFF);
		drain();
		set_heap(32'd0, 32'd0);
		send_request(1'b0, 32'd1, 32'd0);
		drain();
	endtask

	task automatic test_wraparound();
		set_heap(32'hFFFF_FFF0, 32'hFFFF_FFFF);
		send_request(1'b0, 32'd8, 32'd0);
		send_request(1'b0, 32'd16, 32'd0);          // crosses the top of the space
		send_request(1'b0, 32'h8000_0000, 32'd0);
		send_request(1'b1, 32'd0, 32'hFFFF_FFF8);
		send_request(1'b1, 32'd0, m_base + 32'd8 + 32'd16 - 32'd16 + 32'd16);
		send_request(1'b0, 32'd20, 32'd0);
		send_request(1'b0, 32'h7FFF_FFFF, 32'd0);
		drain();
	endtask

	task automatic test_table_limits();
		logic [31:0] snap[$];
		logic [31:0] bumped[$];
		drain();
		set_heap(32'h0001_0000, 32'hFFFF_FFFF);
		// clear out what earlier tests left allocated
		snap = used_st;
		foreach (snap[i]) send_request(1'b1, 32'd0, snap[i]);
		for (int i = 0; i < DEPTH + 1; i++) send_request(1'b0, 32'd1, 32'd0);
		snap = used_st;
		for (int i = 1; i < snap.size(); i += 2) send_request(1'b1, 32'd0, snap[i]);
		for (int i = 0; i < DEPTH / 2; i++) begin
			send_request(1'b0, 32'd2, 32'd0);
			bumped.push_back(pending_results[$].addr);
		end
		foreach (bumped[i]) send_request(1'b1, 32'd0, bumped[i]);
		send_request(1'b1, 32'd0, snap[0]);         // free table full
		send_request(1'b0, 32'd1, 32'd0);           // coalesce makes room
		drain();
	endtask

	task automatic test_random(int n, logic [31:0] base, logic [31:0] limit);
		int r;
		logic [31:0] size;
		set_heap(base, limit);
		for (int k = 0; k < n; k++) begin
			if (k == n / 2) drain();
			r = $urandom_range(0, 99);
			if (r < 5) size = $urandom;
			else if (r < 8) size = 32'd0;
			else size = $urandom_range(1, 256);
			r = $urandom_range(0, 99);
			if (r < 42 && used_st.size() > 0)
				send_request(1'b1, $urandom,
				             used_st[$urandom_range(0, used_st.size() - 1)]);
			else if (r < 47)
				send_request(1'b1, $urandom, $urandom);
			else
				send_request(1'b0, size, $urandom);
		end
		drain();
	endtask

	initial begin
		errors = 0;
		cycles = 0;
		tx_idle = 29;
		rx_idle = 59;
		arst_n = 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_HEAP_BASE;
		cfg_wdata <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= 1'b0;
		m_axis_tready <= 1'b0;
		m_base = 32'd0;
		m_limit = HEAP_LIMIT_RST;
		m_grown = '0;
		m_live = '0;
		m_total = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic();
		test_wraparound();
		test_table_limits();
		test_random(270, $urandom, 32'hFFFF_FFFF);
		tx_idle = 59;
		rx_idle = 29;
		test_random(270, 32'd0, m_grown + 32'd20000);
		tx_idle = 0;
		rx_idle = 0;
		test_random(270, 32'hFFFF_FF00, 32'hFFFF_FFFF);

		repeat (50) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("first_fit_chunk_allocator_unit_tb: PASS");
		end else begin
			$display("first_fit_chunk_allocator_unit_tb: FAIL");
		end
		$finish;
	end
endmodule

/* filelist.f */
+incdir+src
src/ffca_pkg.sv
src/ffca_ram.sv
src/first_fit_chunk_allocator_unit.sv
tb/first_fit_chunk_allocator_unit_tb.sv
